// ===== rtl/ltsm_pkg.sv =====
// Package for the loop timing statistics monitor: opcodes, register and
// statistic indexes, reset values and the structs passed between modules.
// Depends on nothing; every other file of the block imports it.
package ltsm_pkg;

  localparam int unsigned OP_W      = 4;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned STAT_W    = 64;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned PBIN_N    = 5;
  localparam int unsigned EBIN_N    = 4;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 4'd0,
    OP_BEGIN   = 4'd1,
    OP_END     = 4'd2,
    OP_CATCHUP = 4'd3,
    OP_DROP    = 4'd4,
    OP_CH0     = 4'd5,
    OP_CH1     = 4'd6,
    OP_CH2     = 4'd7,
    OP_READ    = 4'd8
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_EDGE_LOW  = 3'd0,
    CFG_PERIOD_EDGE_MID  = 3'd1,
    CFG_PERIOD_EDGE_HIGH = 3'd2,
    CFG_EXEC_EDGE_LOW    = 3'd3,
    CFG_EXEC_EDGE_HIGH   = 3'd4,
    CFG_SLOW_LIMIT       = 3'd5
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] EDGE_LOW_RST  = 32'd10;
  localparam logic [CFG_W-1:0] EDGE_MID_RST  = 32'd20;
  localparam logic [CFG_W-1:0] EDGE_HIGH_RST = 32'd30;
  localparam logic [VAL_W-1:0] MIN_RST       = 32'hFFFF_FFFF;

  // Statistic read indexes.
  localparam int unsigned STAT_LOOP_COUNT   = 0;
  localparam int unsigned STAT_PSAMPLES     = 1;
  localparam int unsigned STAT_PMIN         = 2;
  localparam int unsigned STAT_PMAX         = 3;
  localparam int unsigned STAT_PTOTAL       = 4;
  localparam int unsigned STAT_PBIN_BASE    = 5;
  localparam int unsigned STAT_ESAMPLES     = 10;
  localparam int unsigned STAT_EMAX         = 11;
  localparam int unsigned STAT_EBIN_BASE    = 12;
  localparam int unsigned STAT_CATCHUP_EVT  = 16;
  localparam int unsigned STAT_CATCHUP_STEP = 17;
  localparam int unsigned STAT_DROPS        = 18;
  localparam int unsigned STAT_CH_BASE      = 19;
  localparam int unsigned STAT_COUNT        = 28;

  typedef struct packed {
    logic [CFG_W-1:0] period_edge_low;
    logic [CFG_W-1:0] period_edge_mid;
    logic [CFG_W-1:0] period_edge_high;
    logic [CFG_W-1:0] exec_edge_low;
    logic [CFG_W-1:0] exec_edge_high;
    logic [CFG_W-1:0] slow_limit;
  } cfg_t;

  // One event handed from the input register to the statistics core.
  typedef struct packed {
    logic             fire;
    op_e              op;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] idx;
  } ev_t;

endpackage

// ===== rtl/ltsm_if.sv =====
// Channel interfaces of the loop timing statistics monitor: the event input
// and the statistic result. Depends on ltsm_pkg for the field widths.
interface ltsm_in_if;
  import ltsm_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [VAL_W-1:0] item_value;
  logic [IDX_W-1:0] stat_index;

  modport source (output valid, output op, output item_value, output stat_index,
                  input ready);
  modport sink   (input valid, input op, input item_value, input stat_index,
                  output ready);
endinterface

interface ltsm_out_if;
  import ltsm_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] stat_value;

  modport source (output valid, output stat_value, input ready);
  modport sink   (input valid, input stat_value, output ready);
endinterface

// ===== rtl/ltsm_core.sv =====
// Statistics core: holds every counter, extreme, sum and histogram bin and
// updates them for one event per cycle. Depends on ltsm_pkg.
module ltsm_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ltsm_pkg::ev_t                 ev_i,
  input  ltsm_pkg::cfg_t                cfg_i,
  output logic [ltsm_pkg::STAT_W-1:0]   rd_data_o
);
  import ltsm_pkg::*;

  logic [VAL_W-1:0] loop_count_q, loop_count_d;
  logic [VAL_W-1:0] psamples_q, psamples_d;
  logic [VAL_W-1:0] pmin_q, pmin_d;
  logic [VAL_W-1:0] pmax_q, pmax_d;
  logic [STAT_W-1:0] ptotal_q, ptotal_d;
  logic [VAL_W-1:0] pbin_q [PBIN_N];
  logic [VAL_W-1:0] pbin_d [PBIN_N];
  logic [VAL_W-1:0] esamples_q, esamples_d;
  logic [VAL_W-1:0] emax_q, emax_d;
  logic [VAL_W-1:0] ebin_q [EBIN_N];
  logic [VAL_W-1:0] ebin_d [EBIN_N];
  logic [VAL_W-1:0] cu_events_q, cu_events_d;
  logic [VAL_W-1:0] cu_steps_q, cu_steps_d;
  logic [VAL_W-1:0] drops_q, drops_d;
  logic [VAL_W-1:0] ch_count_q [NUM_CH];
  logic [VAL_W-1:0] ch_count_d [NUM_CH];
  logic [VAL_W-1:0] ch_max_q [NUM_CH];
  logic [VAL_W-1:0] ch_max_d [NUM_CH];
  logic [VAL_W-1:0] ch_slow_q [NUM_CH];
  logic [VAL_W-1:0] ch_slow_d [NUM_CH];
  logic [VAL_W-1:0] prev_start_q, prev_start_d;
  logic [VAL_W-1:0] cur_start_q, cur_start_d;
  logic             have_prev_q, have_prev_d;

  logic [VAL_W-1:0] period, exec_time;
  logic [2:0]       pbin_sel;
  logic [1:0]       ebin_sel;
  logic [1:0]       ch_sel;
  logic [STAT_W-1:0] view [STAT_COUNT];

  assign period    = ev_i.value - prev_start_q;
  assign exec_time = ev_i.value - cur_start_q;
  assign ch_sel    = 2'(ev_i.op - OP_CH0);

  // Bin selection follows the edge order, so disordered edges pick the first match.
  always_comb begin
    priority if (period == '0)                      pbin_sel = 3'd0;
    else if (period <= cfg_i.period_edge_low)       pbin_sel = 3'd1;
    else if (period <= cfg_i.period_edge_mid)       pbin_sel = 3'd2;
    else if (period <= cfg_i.period_edge_high)      pbin_sel = 3'd3;
    else                                            pbin_sel = 3'd4;
  end

  always_comb begin
    priority if (exec_time == '0)                   ebin_sel = 2'd0;
    else if (exec_time <= cfg_i.exec_edge_low)      ebin_sel = 2'd1;
    else if (exec_time <= cfg_i.exec_edge_high)     ebin_sel = 2'd2;
    else                                            ebin_sel = 2'd3;
  end

  always_comb begin
    loop_count_d = loop_count_q;
    psamples_d   = psamples_q;
    pmin_d       = pmin_q;
    pmax_d       = pmax_q;
    ptotal_d     = ptotal_q;
    pbin_d       = pbin_q;
    esamples_d   = esamples_q;
    emax_d       = emax_q;
    ebin_d       = ebin_q;
    cu_events_d  = cu_events_q;
    cu_steps_d   = cu_steps_q;
    drops_d      = drops_q;
    ch_count_d   = ch_count_q;
    ch_max_d     = ch_max_q;
    ch_slow_d    = ch_slow_q;
    prev_start_d = prev_start_q;
    cur_start_d  = cur_start_q;
    have_prev_d  = have_prev_q;

    if (ev_i.fire) begin
      unique case (ev_i.op)
        OP_CLEAR: begin
          loop_count_d = '0;
          psamples_d   = '0;
          pmin_d       = MIN_RST;
          pmax_d       = '0;
          ptotal_d     = '0;
          esamples_d   = '0;
          emax_d       = '0;
          cu_events_d  = '0;
          cu_steps_d   = '0;
          drops_d      = '0;
          prev_start_d = '0;
          cur_start_d  = '0;
          have_prev_d  = 1'b0;
          for (int b = 0; b < PBIN_N; b++) pbin_d[b] = '0;
          for (int b = 0; b < EBIN_N; b++) ebin_d[b] = '0;
          for (int c = 0; c < NUM_CH; c++) begin
            ch_count_d[c] = '0;
            ch_max_d[c]   = '0;
            ch_slow_d[c]  = '0;
          end
        end
        OP_BEGIN: begin
          loop_count_d = loop_count_q + 1'b1;
          cur_start_d  = ev_i.value;
          prev_start_d = ev_i.value;
          have_prev_d  = 1'b1;
          if (have_prev_q) begin
            psamples_d = psamples_q + 1'b1;
            if (period < pmin_q) pmin_d = period;
            if (period > pmax_q) pmax_d = period;
            ptotal_d = ptotal_q + {{(STAT_W-VAL_W){1'b0}}, period};
            for (int b = 0; b < PBIN_N; b++) begin
              if (pbin_sel == 3'(b)) pbin_d[b] = pbin_q[b] + 1'b1;
            end
          end
        end
        OP_END: begin
          esamples_d = esamples_q + 1'b1;
          if (exec_time > emax_q) emax_d = exec_time;
          for (int b = 0; b < EBIN_N; b++) begin
            if (ebin_sel == 2'(b)) ebin_d[b] = ebin_q[b] + 1'b1;
          end
        end
        OP_CATCHUP: begin
          if (ev_i.value != '0) begin
            cu_events_d = cu_events_q + 1'b1;
            cu_steps_d  = cu_steps_q + ev_i.value;
          end
        end
        OP_DROP: drops_d = drops_q + 1'b1;
        OP_CH0, OP_CH1, OP_CH2: begin
          for (int c = 0; c < NUM_CH; c++) begin
            if (ch_sel == 2'(c)) begin
              ch_count_d[c] = ch_count_q[c] + 1'b1;
              if (ev_i.value > ch_max_q[c]) ch_max_d[c] = ev_i.value;
              if (ev_i.value > cfg_i.slow_limit) ch_slow_d[c] = ch_slow_q[c] + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_count_q <= '0;
      psamples_q   <= '0;
      pmin_q       <= MIN_RST;
      pmax_q       <= '0;
      ptotal_q     <= '0;
      esamples_q   <= '0;
      emax_q       <= '0;
      cu_events_q  <= '0;
      cu_steps_q   <= '0;
      drops_q      <= '0;
      prev_start_q <= '0;
      cur_start_q  <= '0;
      have_prev_q  <= 1'b0;
      for (int b = 0; b < PBIN_N; b++) pbin_q[b] <= '0;
      for (int b = 0; b < EBIN_N; b++) ebin_q[b] <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        ch_count_q[c] <= '0;
        ch_max_q[c]   <= '0;
        ch_slow_q[c]  <= '0;
      end
    end else begin
      loop_count_q <= loop_count_d;
      psamples_q   <= psamples_d;
      pmin_q       <= pmin_d;
      pmax_q       <= pmax_d;
      ptotal_q     <= ptotal_d;
      esamples_q   <= esamples_d;
      emax_q       <= emax_d;
      cu_events_q  <= cu_events_d;
      cu_steps_q   <= cu_steps_d;
      drops_q      <= drops_d;
      prev_start_q <= prev_start_d;
      cur_start_q  <= cur_start_d;
      have_prev_q  <= have_prev_d;
      pbin_q       <= pbin_d;
      ebin_q       <= ebin_d;
      ch_count_q   <= ch_count_d;
      ch_max_q     <= ch_max_d;
      ch_slow_q    <= ch_slow_d;
    end
  end

  // Flat view of all statistics in read-index order, zero-extended.
  always_comb begin
    view[STAT_LOOP_COUNT]   = STAT_W'(loop_count_q);
    view[STAT_PSAMPLES]     = STAT_W'(psamples_q);
    // The minimum reads zero until the first period has been measured.
    view[STAT_PMIN]         = (psamples_q == '0) ? '0 : STAT_W'(pmin_q);
    view[STAT_PMAX]         = STAT_W'(pmax_q);
    view[STAT_PTOTAL]       = ptotal_q;
    for (int b = 0; b < PBIN_N; b++) view[STAT_PBIN_BASE + b] = STAT_W'(pbin_q[b]);
    view[STAT_ESAMPLES]     = STAT_W'(esamples_q);
    view[STAT_EMAX]         = STAT_W'(emax_q);
    for (int b = 0; b < EBIN_N; b++) view[STAT_EBIN_BASE + b] = STAT_W'(ebin_q[b]);
    view[STAT_CATCHUP_EVT]  = STAT_W'(cu_events_q);
    view[STAT_CATCHUP_STEP] = STAT_W'(cu_steps_q);
    view[STAT_DROPS]        = STAT_W'(drops_q);
    for (int c = 0; c < NUM_CH; c++) begin
      view[STAT_CH_BASE + 3*c]     = STAT_W'(ch_count_q[c]);
      view[STAT_CH_BASE + 3*c + 1] = STAT_W'(ch_max_q[c]);
      view[STAT_CH_BASE + 3*c + 2] = STAT_W'(ch_slow_q[c]);
    end
  end

  assign rd_data_o = (ev_i.idx < IDX_W'(STAT_COUNT)) ? view[ev_i.idx] : '0;

endmodule

// ===== rtl/loop_timing_statistics_monitor.sv =====
// Top level of the loop timing statistics monitor: input register,
// configuration registers, statistics core and result register.
// Depends on ltsm_pkg, ltsm_if (ltsm_in_if, ltsm_out_if) and ltsm_core.
//
//   channel   direction  transactions carry
//   --------  ---------  -----------------------------------------------
//   in_i      sink       op, item_value, stat_index: one event
//   out_o     source     stat_value: one result per read event
//   cfg_*     input      write enable, register index, 32-bit data
//
// An event is held in the input register and updates the statistics at the
// edge at which it leaves it; a read loads the result register at that edge,
// from which its result is then taken. One event per cycle is
// accepted; input ready drops only while a read waits behind a full result
// register that is not being taken. Reset is asynchronous and active low; it
// clears all statistics and loads the default bin edges and slow limit.
module loop_timing_statistics_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ltsm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ltsm_pkg::CFG_W-1:0]       cfg_data_i,
  ltsm_in_if.sink                          in_i,
  ltsm_out_if.source                       out_o
);
  import ltsm_pkg::*;

  cfg_t cfg_q;

  logic              s1_valid_q;
  logic [OP_W-1:0]   s1_op_q;
  logic [VAL_W-1:0]  s1_value_q;
  logic [IDX_W-1:0]  s1_idx_q;

  logic              out_valid_q;
  logic [STAT_W-1:0] out_data_q;

  logic              s1_is_read;
  logic              stall;
  logic              in_ready;
  ev_t               ev;
  logic [STAT_W-1:0] rd_data;

  // Configuration registers. Indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_edge_low  <= EDGE_LOW_RST;
      cfg_q.period_edge_mid  <= EDGE_MID_RST;
      cfg_q.period_edge_high <= EDGE_HIGH_RST;
      cfg_q.exec_edge_low    <= EDGE_LOW_RST;
      cfg_q.exec_edge_high   <= EDGE_MID_RST;
      cfg_q.slow_limit       <= EDGE_LOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PERIOD_EDGE_LOW:  cfg_q.period_edge_low  <= cfg_data_i;
        CFG_PERIOD_EDGE_MID:  cfg_q.period_edge_mid  <= cfg_data_i;
        CFG_PERIOD_EDGE_HIGH: cfg_q.period_edge_high <= cfg_data_i;
        CFG_EXEC_EDGE_LOW:    cfg_q.exec_edge_low    <= cfg_data_i;
        CFG_EXEC_EDGE_HIGH:   cfg_q.exec_edge_high   <= cfg_data_i;
        CFG_SLOW_LIMIT:       cfg_q.slow_limit       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Only a read needs the result register; every other event always proceeds.
  assign s1_is_read = (op_e'(s1_op_q) == OP_READ);
  assign stall      = s1_valid_q && s1_is_read && out_valid_q && !out_o.ready;
  assign in_ready   = !s1_valid_q || !stall;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_op_q    <= in_i.op;
      s1_value_q <= in_i.item_value;
      s1_idx_q   <= in_i.stat_index;
    end
  end

  assign ev.fire  = s1_valid_q && !stall;
  assign ev.op    = op_e'(s1_op_q);
  assign ev.value = s1_value_q;
  assign ev.idx   = s1_idx_q;

  ltsm_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ev_i      (ev),
    .cfg_i     (cfg_q),
    .rd_data_o (rd_data)
  );

  // Result register: the core's read mux sees all earlier events already applied.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ev.fire && s1_is_read) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev.fire && s1_is_read) begin
      out_data_q <= rd_data;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.stat_value = out_data_q;

endmodule

// ===== rtl/ltsm_checker.sv =====
// Port-level checker for the loop timing statistics monitor, bound to the
// top level. Depends on ltsm_pkg and loop_timing_statistics_monitor.
module ltsm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [ltsm_pkg::OP_W-1:0]       in_op,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ltsm_pkg::STAT_W-1:0]     out_data
);
  import ltsm_pkg::*;

  // Input back-pressure only ever comes from a stalled result.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a stalled result");

  // A fresh result follows a read transaction that passed through the input register and then the result register.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_op == OP_READ), 2))
    else $error("result appeared without a read transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind loop_timing_statistics_monitor ltsm_checker u_ltsm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_op     (in_i.op),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.stat_value)
);
